FILE: src/kpc_pkg.sv
// Shared types and constants for the keypad press classifier.
// No dependencies; every other file of the block imports this package.
package kpc_pkg;

  // Geometry of the key matrix.
  localparam int ROW_COUNT    = 4;
  localparam int COLUMN_COUNT = 3;
  localparam int MATRIX_W     = 12;
  localparam int KEY_TOTAL    = ROW_COUNT * COLUMN_COUNT;
  // Only closures inside the matrix and inside the input field are looked at.
  localparam int KEY_SCAN     = (KEY_TOTAL < MATRIX_W) ? KEY_TOTAL : MATRIX_W;

  // Field widths.
  localparam int KEY_W   = 4;
  localparam int TIME_W  = 32;
  localparam int CFG_W   = 16;
  localparam int TALLY_W = 2;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd2;

  // Configuration reset values.
  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd50;
  localparam logic [CFG_W-1:0] DOUBLE_RESET   = 16'd300;
  localparam logic [CFG_W-1:0] LONG_RESET     = 16'd1000;

  // Tally saturation point.
  localparam logic [TALLY_W-1:0] TALLY_MAX = 2'd3;
  localparam logic [TALLY_W-1:0] TALLY_ONE = 2'd1;
  localparam logic [TALLY_W-1:0] TALLY_TWO = 2'd2;

  // Event codes reported per item.
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } event_kind_e;

  // Timing configuration handed to the classifier.
  typedef struct packed {
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] double_window_ticks;
    logic [CFG_W-1:0] long_hold_ticks;
  } timing_cfg_t;

endpackage

FILE: src/kpc_key_pick.sv
// Priority picker: returns the lowest-numbered closed key as 1..N, 0 if none.
// Depends on kpc_pkg for the matrix geometry.
module kpc_key_pick import kpc_pkg::*; (
  input  logic [MATRIX_W-1:0] key_matrix_i,
  output logic [KEY_W-1:0]    key_o
);

  // Scan from the top down so that the lowest closed bit wins.
  always_comb begin
    key_o = '0;
    for (int i = KEY_SCAN - 1; i >= 0; i--) begin
      if (key_matrix_i[i]) begin
        key_o = KEY_W'(i + 1);
      end
    end
  end

endmodule

FILE: src/kpc_press_fsm.sv
// Press state and event classification, one item per enabled cycle.
// Depends on kpc_pkg for widths, event codes and the timing configuration.
module kpc_press_fsm import kpc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [KEY_W-1:0]  key_i,
  input  timing_cfg_t       cfg_i,
  output event_kind_e       event_kind_o,
  output logic [KEY_W-1:0]  key_index_o
);

  logic [TIME_W-1:0]  tick_q, tick_d;
  logic [KEY_W-1:0]   held_q, held_d;
  logic [TIME_W-1:0]  press_time_q, press_time_d;
  logic [TIME_W-1:0]  hold_start_q, hold_start_d;
  logic [TALLY_W-1:0] tally_q, tally_d;
  logic               down_q, down_d;
  logic               long_rep_q, long_rep_d;

  logic [TIME_W-1:0]  since_press;
  logic [TIME_W-1:0]  since_hold;
  logic [TIME_W-1:0]  since_press_n;
  logic [TIME_W-1:0]  since_hold_n;
  logic               debounced;
  logic               press_acc;
  logic               release_acc;
  logic [KEY_W-1:0]   held_mid;
  logic [TALLY_W-1:0] tally_mid;

  // Elapsed times against the current tick, with wrapping subtraction.
  assign since_press = tick_q - press_time_q;
  assign since_hold  = tick_q - hold_start_q;
  assign debounced   = since_press > TIME_W'(cfg_i.debounce_ticks);
  assign press_acc   = (key_i != '0) && !down_q && debounced;
  assign release_acc = (key_i == '0) && down_q && debounced;
  // A press just taken restarts both clocks at this tick.
  assign since_press_n = press_acc ? '0 : since_press;
  assign since_hold_n  = press_acc ? '0 : since_hold;

  // Press and release debounce, then event classification.
  always_comb begin
    tick_d       = tick_q + TIME_W'(1);
    down_d       = down_q;
    press_time_d = press_time_q;
    hold_start_d = hold_start_q;
    tally_mid    = tally_q;
    held_mid     = held_q;
    long_rep_d   = long_rep_q;
    event_kind_o = EV_NONE;
    key_index_o  = '0;

    if (press_acc) begin
      down_d       = 1'b1;
      hold_start_d = tick_q;
      press_time_d = tick_q;
      held_mid     = key_i;
      if (key_i == held_q && since_press < TIME_W'(cfg_i.double_window_ticks)) begin
        if (tally_q != TALLY_MAX) begin
          tally_mid = tally_q + TALLY_W'(1);
        end
      end else begin
        tally_mid = TALLY_ONE;
      end
    end else if (release_acc) begin
      down_d = 1'b0;
    end

    held_d  = held_mid;
    tally_d = tally_mid;

    if (down_d && since_hold_n > TIME_W'(cfg_i.long_hold_ticks)) begin
      if (!long_rep_q) begin
        long_rep_d   = 1'b1;
        event_kind_o = EV_LONG;
        key_index_o  = held_mid;
      end
    end else if (!down_d && held_mid != '0) begin
      // The release of a long press is swallowed.
      priority if (long_rep_q) begin
        long_rep_d = 1'b0;
        held_d     = '0;
        tally_d    = '0;
      end else if (tally_mid == TALLY_ONE &&
                   since_press_n > TIME_W'(cfg_i.double_window_ticks)) begin
        event_kind_o = EV_SINGLE;
        key_index_o  = held_mid;
        held_d       = '0;
        tally_d      = '0;
      end else if (tally_mid == TALLY_TWO) begin
        event_kind_o = EV_DOUBLE;
        key_index_o  = held_mid;
        held_d       = '0;
        tally_d      = '0;
      end else begin
        // A single press still inside its window, or a saturated tally: no event.
      end
    end
  end

  // State advances only when an item is processed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q       <= '0;
      held_q       <= '0;
      press_time_q <= '0;
      hold_start_q <= '0;
      tally_q      <= '0;
      down_q       <= 1'b0;
      long_rep_q   <= 1'b0;
    end else if (step_i) begin
      tick_q       <= tick_d;
      held_q       <= held_d;
      press_time_q <= press_time_d;
      hold_start_q <= hold_start_d;
      tally_q      <= tally_d;
      down_q       <= down_d;
      long_rep_q   <= long_rep_d;
    end
  end

endmodule

FILE: src/keypad_press_classifier.sv
// Top level of the keypad press classifier: ports, item registers, config.
// Depends on kpc_pkg, kpc_key_pick and kpc_press_fsm.

// Each accepted item is one millisecond tick of key matrix closures and
// yields exactly one result item (event kind and key index). The block
// takes one item per clock cycle while the result is not stalled. An item
// accepted waits in the input register until the result register is free or
// draining; its result then goes into the result register and is offered
// from there. A stalled result holds the input register, which then stalls
// the input. The classification logic between the two registers is a priority
// pick and a few 32-bit subtract-and-compare steps against the timing
// registers. Timing registers are written through the configuration port,
// which is always ready; write them only while no item is in flight.
module keypad_press_classifier import kpc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input channel.
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [MATRIX_W-1:0]  key_matrix_i,
  // Result channel.
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           event_kind_o,
  output logic [KEY_W-1:0]     key_index_o,
  // Configuration write channel.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  logic                in_valid_q;
  logic [MATRIX_W-1:0] matrix_q;
  logic                out_valid_q;
  event_kind_e         kind_q;
  logic [KEY_W-1:0]    index_q;
  timing_cfg_t         cfg_q;

  logic                advance;
  logic                in_accept;
  logic [KEY_W-1:0]    key;
  event_kind_e         kind;
  logic [KEY_W-1:0]    index;

  // The input register moves on whenever the result register is free or draining.
  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      matrix_q <= key_matrix_i;
    end
  end

  // Timing configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks      <= DEBOUNCE_RESET;
      cfg_q.double_window_ticks <= DOUBLE_RESET;
      cfg_q.long_hold_ticks     <= LONG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_DEBOUNCE: cfg_q.debounce_ticks      <= cfg_wdata_i;
        CFG_DOUBLE:   cfg_q.double_window_ticks <= cfg_wdata_i;
        CFG_LONG:     cfg_q.long_hold_ticks     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  kpc_key_pick u_key_pick (
    .key_matrix_i (matrix_q),
    .key_o        (key)
  );

  kpc_press_fsm u_press_fsm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .key_i        (key),
    .cfg_i        (cfg_q),
    .event_kind_o (kind),
    .key_index_o  (index)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      kind_q  <= kind;
      index_q <= index;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_kind_o = kind_q;
  assign key_index_o  = index_q;

endmodule
